>>> sv/trial_division_prime_test_assert.svh
// ============================================================================
// Assertion macros for the trial division prime test
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ============================================================================
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Same-cycle implication.
`define TDPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trial division prime test: assertion failed");

// Next-cycle implication.
`define TDPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trial division prime test: assertion failed");

`endif

>>> sv/trd_pkg.sv
// ============================================================================
// Trial division prime test package
// Widths, state encoding and the control structs shared by the modules.
// ============================================================================
package trd_pkg;

    localparam int VALUE_WIDTH   = 16;
    localparam int BIT_CNT_W     = $clog2(VALUE_WIDTH);
    localparam int SQ_W          = 2 * VALUE_WIDTH;
    localparam int IN_TDATA_W    = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = 8;
    localparam int FIRST_DIVISOR = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [VALUE_WIDTH-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_rem_rsp;

endpackage

>>> sv/trd_rem.sv
// ============================================================================
// Bit-serial remainder unit
// Shifts the dividend in one bit per cycle, most significant bit first, and
// reports whether the remainder by the divisor is zero.
// ============================================================================
module trd_rem
    import trd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    logic [VALUE_WIDTH-1:0] r_shift;
    logic [VALUE_WIDTH-1:0] n_shift;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] n_rem;
    logic [VALUE_WIDTH-1:0] r_divisor;
    logic [VALUE_WIDTH-1:0] n_divisor;
    logic [BIT_CNT_W-1:0]   r_cnt;
    logic [BIT_CNT_W-1:0]   n_cnt;
    logic                   r_busy;
    logic                   n_busy;
    logic                   r_done;
    logic                   n_done;
    logic                   r_zero;
    logic                   n_zero;

    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH-1:0] w_step_rem;
    logic                   w_last;

    assign w_trial    = {r_rem, r_shift[VALUE_WIDTH-1]};
    assign w_step_rem = (w_trial >= {1'b0, r_divisor})
                      ? VALUE_WIDTH'(w_trial - {1'b0, r_divisor})
                      : w_trial[VALUE_WIDTH-1:0];
    assign w_last     = (r_cnt == BIT_CNT_W'(VALUE_WIDTH - 1));

    always_comb begin
        n_shift   = r_shift;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_zero    = r_zero;
        if (i_req.start) begin
            n_shift   = i_req.dividend;
            n_rem     = '0;
            n_divisor = i_req.divisor;
            n_cnt     = '0;
            n_busy    = 1'b1;
        end else if (r_busy) begin
            n_shift = {r_shift[VALUE_WIDTH-2:0], 1'b0};
            n_rem   = w_step_rem;
            n_cnt   = r_cnt + BIT_CNT_W'(1);
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_zero = (w_step_rem == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift   <= n_shift;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_zero    <= n_zero;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.zero = r_zero;

`include "trial_division_prime_test_assert.svh"

    `TDPT_ASSERT_NOW(a_start_when_idle, i_req.start, !r_busy)
    `TDPT_ASSERT_NEXT(a_done_after_last_bit, r_busy && w_last && !i_req.start, r_done)
    `TDPT_ASSERT_NOW(a_done_not_busy, r_done, !r_busy)

endmodule

>>> sv/trial_division_prime_test.sv
// ============================================================================
// Trial division prime test
// Reports for each input word whether the number is prime.
// ============================================================================
// One number is tested at a time. Divisors are tried from 2 upward while the
// divisor squared does not exceed the number. Each trial takes one check state
// plus a pass through the bit-serial remainder unit (its shift steps and its
// done strobe). A composite number stops at its smallest divisor. The numbers
// 0 to 3 are settled in the check state without a trial division. A number of
// 0 or 1 gives bad_input high and is_prime low. The result sits in an output
// register, so the next word is taken while it waits. A finished word is held
// back as long as that register holds an unread result.
module trial_division_prime_test
    import trd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // value
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // is_prime, bad_input
);

    t_state                 r_state;
    t_state                 n_state;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [SQ_W-1:0]        r_sq;
    logic                   r_prime;
    logic                   r_bad;
    logic                   r_out_valid;
    logic                   r_out_prime;
    logic                   r_out_bad;

    logic     w_accept;
    logic     w_bad;
    logic     w_sq_over;
    logic     w_load_out;
    t_rem_req w_rem_req;
    t_rem_rsp w_rem_rsp;

    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_bad     = (r_value < VALUE_WIDTH'(FIRST_DIVISOR));
    assign w_sq_over = (r_sq > SQ_W'(r_value));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_bad || w_sq_over) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (w_rem_rsp.done) begin
                    n_state = w_rem_rsp.zero ? ST_DONE : ST_CHECK;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready    = 1'b0;
        w_rem_req.start    = 1'b0;
        w_rem_req.dividend = r_value;
        w_rem_req.divisor  = r_div;
        w_load_out         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            ST_CHECK: begin
                w_rem_req.start = !w_bad && !w_sq_over;
            end
            ST_DIVIDE: begin
            end
            ST_DONE: begin
                w_load_out = !r_out_valid || i_m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    trd_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_rsp   (w_rem_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_s_axis_tdata[VALUE_WIDTH-1:0];
            r_div   <= VALUE_WIDTH'(FIRST_DIVISOR);
            r_sq    <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
        end else if (r_state == ST_DIVIDE && w_rem_rsp.done && !w_rem_rsp.zero) begin
            r_div <= r_div + VALUE_WIDTH'(1);
            r_sq  <= r_sq + SQ_W'({r_div, 1'b1});
        end
        if (r_state == ST_CHECK) begin
            r_bad   <= w_bad;
            r_prime <= !w_bad && w_sq_over;
        end else if (r_state == ST_DIVIDE && w_rem_rsp.done && w_rem_rsp.zero) begin
            r_prime <= 1'b0;
        end
        if (w_load_out) begin
            r_out_prime <= r_prime;
            r_out_bad   <= r_bad;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - 2)'(0), r_out_bad, r_out_prime};

`include "trial_division_prime_test_assert.svh"

    `TDPT_ASSERT_NOW(a_bad_not_prime, o_m_axis_tvalid, !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
    `TDPT_ASSERT_NOW(a_divide_within_bound, r_state == ST_DIVIDE, !w_sq_over && !w_bad)
    `TDPT_ASSERT_NOW(a_rem_done_in_divide, w_rem_rsp.done, r_state == ST_DIVIDE)
    `TDPT_ASSERT_NOW(a_rem_idle_outside_divide, r_state != ST_DIVIDE, !w_rem_rsp.busy)

endmodule
